// ----- rtl/subleq_processor_core_unit_defines.svh -----
// Assertion helpers used by the checker file of this project.
`ifndef SUBLEQ_PROCESSOR_CORE_UNIT_DEFINES_SVH
`define SUBLEQ_PROCESSOR_CORE_UNIT_DEFINES_SVH

// Same-cycle implication, switched off while reset is held.
`define SUBLEQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("subleq core check failed");

// Next-cycle implication, switched off while reset is held.
`define SUBLEQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("subleq core check failed");

`endif

// ----- rtl/subleq_pkg.sv -----
`default_nettype none

package subleq_pkg;

    localparam int UPC_W = 4;

    // Command codes of an input item.
    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_EXEC  = 2'd2;
    localparam logic [1:0] CMD_SETPC = 2'd3;

    // Read address sources.
    localparam logic [1:0] RS_PC   = 2'd0;
    localparam logic [1:0] RS_OPA  = 2'd1;
    localparam logic [1:0] RS_OPB  = 2'd2;
    localparam logic [1:0] RS_ADDR = 2'd3;

    // Program counter operations.
    localparam logic [1:0] PC_KEEP = 2'd0;
    localparam logic [1:0] PC_SET  = 2'd1;
    localparam logic [1:0] PC_EXEC = 2'd2;

    // Jump conditions.
    localparam logic [1:0] CND_NONE = 2'd0;
    localparam logic [1:0] CND_ADDR = 2'd1;
    localparam logic [1:0] CND_HALT = 2'd2;
    localparam logic [1:0] CND_OPS  = 2'd3;

    // Result data selection.
    localparam logic [1:0] OUT_ZERO = 2'd0;
    localparam logic [1:0] OUT_MEM  = 2'd1;
    localparam logic [1:0] OUT_RES  = 2'd2;

    // Microprogram step addresses.
    localparam logic [UPC_W-1:0] U_W0    = 4'd0;
    localparam logic [UPC_W-1:0] U_W1    = 4'd1;
    localparam logic [UPC_W-1:0] U_R0    = 4'd2;
    localparam logic [UPC_W-1:0] U_R1    = 4'd3;
    localparam logic [UPC_W-1:0] U_P0    = 4'd4;
    localparam logic [UPC_W-1:0] U_X0    = 4'd5;
    localparam logic [UPC_W-1:0] U_X1    = 4'd6;
    localparam logic [UPC_W-1:0] U_X2    = 4'd7;
    localparam logic [UPC_W-1:0] U_X3    = 4'd8;
    localparam logic [UPC_W-1:0] U_FAULT = 4'd9;
    localparam logic [UPC_W-1:0] U_NOP   = 4'd10;

    typedef struct packed {
        logic [1:0]       rsrc;
        logic             we;
        logic             wsel;
        logic             ld_ir;
        logic             ld_opa;
        logic [1:0]       pcop;
        logic [1:0]       cond;
        logic [UPC_W-1:0] target;
        logic             strobe;
        logic [1:0]       osel;
        logic             fault;
        logic             last;
    } t_uword;

    typedef struct packed {
        logic addr_bad;
        logic halted;
        logic ops_bad;
    } t_flags;

    function automatic logic [UPC_W-1:0] entry(input logic [1:0] cmd);
        logic [UPC_W-1:0] e;
        case (cmd)
            CMD_WRITE: e = U_W0;
            CMD_READ:  e = U_R0;
            CMD_EXEC:  e = U_X0;
            CMD_SETPC: e = U_P0;
            default:   e = U_NOP;
        endcase
        return e;
    endfunction

    function automatic t_uword ucode(input logic [UPC_W-1:0] upc);
        t_uword w;
        w = '0;
        case (upc)
            U_W0: begin
                w.cond   = CND_ADDR;
                w.target = U_FAULT;
            end
            U_W1: begin
                w.we     = 1'b1;
                w.strobe = 1'b1;
                w.last   = 1'b1;
            end
            U_R0: begin
                w.rsrc   = RS_ADDR;
                w.cond   = CND_ADDR;
                w.target = U_FAULT;
            end
            U_R1: begin
                w.osel   = OUT_MEM;
                w.strobe = 1'b1;
                w.last   = 1'b1;
            end
            U_P0: begin
                w.pcop   = PC_SET;
                w.strobe = 1'b1;
                w.last   = 1'b1;
            end
            U_X0: begin
                w.rsrc   = RS_PC;
                w.cond   = CND_HALT;
                w.target = U_NOP;
            end
            U_X1: begin
                w.ld_ir  = 1'b1;
                w.rsrc   = RS_OPA;
                w.cond   = CND_OPS;
                w.target = U_FAULT;
            end
            U_X2: begin
                w.ld_opa = 1'b1;
                w.rsrc   = RS_OPB;
            end
            U_X3: begin
                w.we     = 1'b1;
                w.wsel   = 1'b1;
                w.pcop   = PC_EXEC;
                w.osel   = OUT_RES;
                w.strobe = 1'b1;
                w.last   = 1'b1;
            end
            U_FAULT: begin
                w.fault  = 1'b1;
                w.strobe = 1'b1;
                w.last   = 1'b1;
            end
            U_NOP: begin
                w.strobe = 1'b1;
                w.last   = 1'b1;
            end
            default: begin
                w.last = 1'b1;
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/subleq_processor_core_unit.sv -----
// Steps from the accepting edge to the registered result strobe, one microcode word each:
// set pc P0, write W0 W1, read R0 R1, execute X0 to X3 (X0 NOP when halted, X0 X1 FAULT
// on an operand fault; W0 or R0 then FAULT on a bad address). A new item is taken in the
// cycle after the strobe-producing step, never while busy; memory has a single read port.
// Synchronous active-low reset clears pc, the sequencer and the per-word valid bits, so
// every memory word reads as zero until written; no clearing pass is needed.
`default_nettype none

module subleq_processor_core_unit #(
    parameter int MEM_WORDS    = 128,
    parameter int OPERAND_BITS = 20
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  i_cmd,
    input  wire logic [7:0]  i_addr,
    input  wire logic [63:0] i_wdata,
    output logic             o_strobe,
    output logic [63:0]      o_rdata,
    output logic [7:0]       o_pc_now,
    output logic             o_jumped,
    output logic             o_halted,
    output logic             o_fault
);

    subleq_pkg::t_uword w_cw;
    subleq_pkg::t_flags w_flags;
    logic               w_accept;

    subleq_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_cmd    (i_cmd),
        .i_flags  (w_flags),
        .o_busy   (busy),
        .o_accept (w_accept),
        .o_cw     (w_cw)
    );

    subleq_dp #(
        .MEM_WORDS    (MEM_WORDS),
        .OPERAND_BITS (OPERAND_BITS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_addr   (i_addr),
        .i_wdata  (i_wdata),
        .i_cw     (w_cw),
        .o_flags  (w_flags),
        .o_strobe (o_strobe),
        .o_rdata  (o_rdata),
        .o_pc_now (o_pc_now),
        .o_jumped (o_jumped),
        .o_halted (o_halted),
        .o_fault  (o_fault)
    );

endmodule

`default_nettype wire

// ----- rtl/subleq_mem.sv -----
`default_nettype none

module subleq_mem #(
    parameter int MEM_WORDS = 128
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_we,
    input  wire logic [$clog2(MEM_WORDS)-1:0] i_waddr,
    input  wire logic [63:0]                  i_wdata,
    input  wire logic [$clog2(MEM_WORDS)-1:0] i_raddr,
    output logic      [63:0]                  o_rdata
);

    logic [63:0]          r_mem [MEM_WORDS];
    logic [MEM_WORDS-1:0] r_vld;
    logic [63:0]          r_q;
    logic                 r_qvld;

    // An entry never written since reset reads as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_we) begin
            r_vld[i_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q    <= r_mem[i_raddr];
        r_qvld <= r_vld[i_raddr];
    end

    assign o_rdata = r_qvld ? r_q : 64'd0;

endmodule

`default_nettype wire

// ----- rtl/subleq_seq.sv -----
`default_nettype none

module subleq_seq (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic [1:0]           i_cmd,
    input  wire subleq_pkg::t_flags   i_flags,
    output logic                      o_busy,
    output logic                      o_accept,
    output subleq_pkg::t_uword        o_cw
);

    logic                         r_busy;
    logic                         n_busy;
    logic [subleq_pkg::UPC_W-1:0] r_upc;
    logic [subleq_pkg::UPC_W-1:0] n_upc;
    subleq_pkg::t_uword           w_word;
    logic                         w_take;

    assign w_word   = subleq_pkg::ucode(r_upc);
    assign o_cw     = r_busy ? w_word : '0;
    assign o_busy   = r_busy;
    assign o_accept = i_start & ~r_busy;

    always_comb begin
        case (w_word.cond)
            subleq_pkg::CND_NONE: w_take = 1'b0;
            subleq_pkg::CND_ADDR: w_take = i_flags.addr_bad;
            subleq_pkg::CND_HALT: w_take = i_flags.halted;
            subleq_pkg::CND_OPS:  w_take = i_flags.ops_bad;
            default:              w_take = 1'b0;
        endcase
    end

    always_comb begin
        n_busy = r_busy;
        n_upc  = r_upc;
        if (!r_busy) begin
            if (i_start) begin
                n_busy = 1'b1;
                n_upc  = subleq_pkg::entry(i_cmd);
            end
        end else if (w_word.last) begin
            n_busy = 1'b0;
        end else if (w_take) begin
            n_upc = w_word.target;
        end else begin
            n_upc = r_upc + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_upc  <= subleq_pkg::U_NOP;
        end else begin
            r_busy <= n_busy;
            r_upc  <= n_upc;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/subleq_dp.sv -----
`default_nettype none

module subleq_dp #(
    parameter int MEM_WORDS    = 128,
    parameter int OPERAND_BITS = 20
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_accept,
    input  wire logic [7:0]         i_addr,
    input  wire logic [63:0]        i_wdata,
    input  wire subleq_pkg::t_uword i_cw,
    output subleq_pkg::t_flags      o_flags,
    output logic                    o_strobe,
    output logic [63:0]             o_rdata,
    output logic [7:0]              o_pc_now,
    output logic                    o_jumped,
    output logic                    o_halted,
    output logic                    o_fault
);

    localparam int AW = $clog2(MEM_WORDS);
    localparam logic [8:0] MW_PC = 9'(MEM_WORDS);
    localparam logic [OPERAND_BITS:0] MW_OP = (OPERAND_BITS+1)'(MEM_WORDS);

    logic [7:0]              r_addr;
    logic [63:0]             r_wdata;
    logic [7:0]              r_pc;
    logic [7:0]              n_pc;
    logic [63:0]             r_ir;
    logic [63:0]             r_opa;
    logic [63:0]             r_rdata;
    logic [7:0]              r_pc_now;
    logic                    r_jumped;
    logic                    r_halted;
    logic                    r_fault;
    logic                    r_strobe;

    logic [63:0]             w_mem_q;
    logic [63:0]             w_ir;
    logic [OPERAND_BITS-1:0] w_a;
    logic [OPERAND_BITS-1:0] w_b;
    logic [OPERAND_BITS-1:0] w_c;
    logic [63:0]             w_res;
    logic                    w_jump;
    logic [AW-1:0]           w_raddr;
    logic [AW-1:0]           w_waddr;
    logic [63:0]             w_wdata;
    logic [63:0]             w_out;

    // The instruction word is taken straight from the memory in the step that loads it.
    assign w_ir  = i_cw.ld_ir ? w_mem_q : r_ir;
    assign w_a   = w_ir[OPERAND_BITS-1:0];
    assign w_b   = w_ir[2*OPERAND_BITS-1:OPERAND_BITS];
    assign w_c   = w_ir[3*OPERAND_BITS-1:2*OPERAND_BITS];

    assign w_res  = w_mem_q - r_opa;
    assign w_jump = (w_res == 64'd0) | w_res[63];

    assign o_flags.addr_bad = {1'b0, r_addr} >= MW_PC;
    assign o_flags.halted   = {1'b0, r_pc} >= MW_PC;
    assign o_flags.ops_bad  = ({1'b0, w_a} >= MW_OP) | ({1'b0, w_b} >= MW_OP);

    always_comb begin
        case (i_cw.rsrc)
            subleq_pkg::RS_PC:   w_raddr = r_pc[AW-1:0];
            subleq_pkg::RS_OPA:  w_raddr = w_a[AW-1:0];
            subleq_pkg::RS_OPB:  w_raddr = w_b[AW-1:0];
            subleq_pkg::RS_ADDR: w_raddr = r_addr[AW-1:0];
            default:             w_raddr = r_addr[AW-1:0];
        endcase
    end

    assign w_waddr = i_cw.wsel ? w_b[AW-1:0] : r_addr[AW-1:0];
    assign w_wdata = i_cw.wsel ? w_res : r_wdata;

    always_comb begin
        case (i_cw.pcop)
            subleq_pkg::PC_KEEP: n_pc = r_pc;
            subleq_pkg::PC_SET:  n_pc = r_addr;
            subleq_pkg::PC_EXEC: n_pc = w_jump ? w_c[7:0] : r_pc + 8'd1;
            default:             n_pc = r_pc;
        endcase
    end

    always_comb begin
        case (i_cw.osel)
            subleq_pkg::OUT_ZERO: w_out = 64'd0;
            subleq_pkg::OUT_MEM:  w_out = w_mem_q;
            subleq_pkg::OUT_RES:  w_out = w_res;
            default:              w_out = 64'd0;
        endcase
    end

    subleq_mem #(
        .MEM_WORDS (MEM_WORDS)
    ) u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cw.we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_mem_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc     <= 8'd0;
            r_strobe <= 1'b0;
        end else begin
            r_pc     <= n_pc;
            r_strobe <= i_cw.strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_addr  <= i_addr;
            r_wdata <= i_wdata;
        end
        if (i_cw.ld_ir) begin
            r_ir <= w_mem_q;
        end
        if (i_cw.ld_opa) begin
            r_opa <= w_mem_q;
        end
        if (i_cw.strobe) begin
            r_rdata  <= w_out;
            r_pc_now <= n_pc;
            r_jumped <= (i_cw.pcop == subleq_pkg::PC_EXEC) & w_jump;
            r_halted <= {1'b0, n_pc} >= MW_PC;
            r_fault  <= i_cw.fault;
        end
    end

    assign o_strobe = r_strobe;
    assign o_rdata  = r_rdata;
    assign o_pc_now = r_pc_now;
    assign o_jumped = r_jumped;
    assign o_halted = r_halted;
    assign o_fault  = r_fault;

endmodule

`default_nettype wire

// ----- rtl/subleq_chk.sv -----
`default_nettype none
`include "subleq_processor_core_unit_defines.svh"

module subleq_chk #(
    parameter int MEM_WORDS = 128
) (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_start,
    input wire logic       i_busy,
    input wire logic       i_strobe,
    input wire logic [7:0] i_pc_now,
    input wire logic       i_jumped,
    input wire logic       i_halted,
    input wire logic       i_fault
);

    localparam logic [8:0] MW_PC = 9'(MEM_WORDS);

    // An accepted item makes the block busy.
    `SUBLEQ_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, i_start && !i_busy, i_busy)
    // The result of an item appears only once its sequence has finished.
    `SUBLEQ_ASSERT_IMP(a_strobe_idle, i_clk, i_rst_n, i_strobe, !i_busy)
    // A taken branch and a fault never come from the same item.
    `SUBLEQ_ASSERT_IMP(a_jump_nofault, i_clk, i_rst_n, i_strobe && i_jumped, !i_fault)
    // The halted flag agrees with the reported program counter.
    `SUBLEQ_ASSERT_IMP(a_halt_pc, i_clk, i_rst_n, i_strobe, i_halted == ({1'b0, i_pc_now} >= MW_PC))

endmodule

bind subleq_processor_core_unit subleq_chk #(
    .MEM_WORDS (MEM_WORDS)
) u_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_start  (start),
    .i_busy   (busy),
    .i_strobe (o_strobe),
    .i_pc_now (o_pc_now),
    .i_jumped (o_jumped),
    .i_halted (o_halted),
    .i_fault  (o_fault)
);

`default_nettype wire

// ----- verif/tb_top.sv -----
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MEM_WORDS    = 128;
    localparam int OPERAND_BITS = 20;
    localparam int OPERAND_MAX  = (1 << OPERAND_BITS) - 1;
    localparam int RANDOM_ITEMS = 1700;
    localparam int QUIET_TAIL   = 300;

    typedef struct packed {
        logic [63:0] rdata;
        logic [7:0]  pc_now;
        logic        jumped;
        logic        halted;
        logic        fault;
    } t_outcome;

    // Mirror of the word memory and program counter; every accepted item is
    // applied here and the outcome it should produce is queued.
    class subleq_mirror;
        logic [63:0] mem_image [MEM_WORDS];
        logic [7:0]  pc_image;
        t_outcome    expected_outcomes[$];
        int unsigned mismatches;

        function new();
            foreach (mem_image[i]) mem_image[i] = '0;
            pc_image   = '0;
            mismatches = 0;
        endfunction

        function int pending();
            return expected_outcomes.size();
        endfunction

        function void note_command(logic [1:0] cmd, logic [7:0] addr, logic [63:0] wdata);
            t_outcome                outc;
            logic [63:0]             instr;
            logic [63:0]             diff;
            logic [OPERAND_BITS-1:0] opa;
            logic [OPERAND_BITS-1:0] opb;
            logic [OPERAND_BITS-1:0] opc;
            outc = '0;
            case (cmd)
                subleq_pkg::CMD_WRITE: begin
                    if (addr < MEM_WORDS) mem_image[addr] = wdata;
                    else outc.fault = 1'b1;
                end
                subleq_pkg::CMD_READ: begin
                    if (addr < MEM_WORDS) outc.rdata = mem_image[addr];
                    else outc.fault = 1'b1;
                end
                subleq_pkg::CMD_SETPC: begin
                    pc_image = addr;
                end
                default: begin
                    // Execute; a halted core leaves everything as it is.
                    if (pc_image < MEM_WORDS) begin
                        instr = mem_image[pc_image];
                        opa   = instr[0 +: OPERAND_BITS];
                        opb   = instr[OPERAND_BITS +: OPERAND_BITS];
                        opc   = instr[2*OPERAND_BITS +: OPERAND_BITS];
                        if (opa >= MEM_WORDS || opb >= MEM_WORDS) begin
                            outc.fault = 1'b1;
                        end else begin
                            diff            = mem_image[opb] - mem_image[opa];
                            mem_image[opb]  = diff;
                            outc.rdata      = diff;
                            if (diff == '0 || diff[63]) begin
                                outc.jumped = 1'b1;
                                pc_image    = opc[7:0];
                            end else begin
                                pc_image    = pc_image + 8'd1;
                            end
                        end
                    end
                end
            endcase
            outc.pc_now = pc_image;
            outc.halted = (pc_image >= MEM_WORDS);
            expected_outcomes.push_back(outc);
        endfunction

        function void check_outcome(t_outcome got);
            t_outcome want;
            if (expected_outcomes.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: rdata=%h pc=%0d jumped=%b halted=%b fault=%b",
                             got.rdata, got.pc_now, got.jumped, got.halted, got.fault);
                return;
            end
            want = expected_outcomes.pop_front();
            if (got.rdata !== want.rdata || got.pc_now !== want.pc_now ||
                got.jumped !== want.jumped || got.halted !== want.halted ||
                got.fault !== want.fault) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected rdata=%h pc=%0d jumped=%b halted=%b fault=%b, %s",
                             want.rdata, want.pc_now, want.jumped, want.halted, want.fault,
                             $sformatf("got rdata=%h pc=%0d jumped=%b halted=%b fault=%b",
                                       got.rdata, got.pc_now, got.jumped, got.halted,
                                       got.fault));
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_cmd;
    logic [7:0]  i_addr;
    logic [63:0] i_wdata;
    logic        o_strobe;
    logic [63:0] o_rdata;
    logic [7:0]  o_pc_now;
    logic        o_jumped;
    logic        o_halted;
    logic        o_fault;

    subleq_mirror sb;
    bit           allow_gaps;
    int unsigned  items_sent;

    subleq_processor_core_unit #(
        .MEM_WORDS    (MEM_WORDS),
        .OPERAND_BITS (OPERAND_BITS)
    ) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_cmd    (i_cmd),
        .i_addr   (i_addr),
        .i_wdata  (i_wdata),
        .o_strobe (o_strobe),
        .o_rdata  (o_rdata),
        .o_pc_now (o_pc_now),
        .o_jumped (o_jumped),
        .o_halted (o_halted),
        .o_fault  (o_fault)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // Results are checked before the item accepted at the same edge is noted,
    // so the queue order always follows the order of acceptance.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_strobe === 1'b1)
                sb.check_outcome('{o_rdata, o_pc_now, o_jumped, o_halted, o_fault});
            if (start && busy === 1'b0)
                sb.note_command(i_cmd, i_addr, i_wdata);
        end
    end

    initial begin
        #5_000_000;
        $display("subleq_processor_core_unit test failed");
        $finish;
    end

    function automatic logic [63:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    // The bits above operand C are filled at random; the core ignores them.
    function automatic logic [63:0] pack_instruction(input int unsigned a, input int unsigned b,
                                                     input int unsigned c);
        logic [63:0] w;
        w = rand_word();
        w[0 +: OPERAND_BITS]              = a[OPERAND_BITS-1:0];
        w[OPERAND_BITS +: OPERAND_BITS]   = b[OPERAND_BITS-1:0];
        w[2*OPERAND_BITS +: OPERAND_BITS] = c[OPERAND_BITS-1:0];
        return w;
    endfunction

    // Data values chosen so that differences land on both sides of zero.
    function automatic logic [63:0] pick_data();
        logic [63:0] v;
        case ($urandom_range(0, 3))
            0:       v = 64'($urandom_range(0, 15));
            1:       v = -64'($urandom_range(0, 15));
            2:       v = rand_word();
            default: v = $urandom_range(0, 1) ? 64'h7fff_ffff_ffff_ffff : 64'h8000_0000_0000_0000;
        endcase
        return v;
    endfunction

    task automatic send_item(input logic [1:0] cmd, input logic [7:0] addr,
                             input logic [63:0] wdata);
        start   <= 1'b1;
        i_cmd   <= cmd;
        i_addr  <= addr;
        i_wdata <= wdata;
        do @(posedge i_clk); while (busy !== 1'b0);
        items_sent++;
        if (allow_gaps && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (sb.pending() > 0) @(posedge i_clk);
    endtask

    // A short program with random operands, mostly in a small data window, then a run of steps.
    task automatic run_program();
        int unsigned pbase;
        int unsigned plen;
        int unsigned dbase;
        int unsigned a;
        int unsigned b;
        int unsigned c;
        pbase = $urandom_range(0, MEM_WORDS - 9);
        plen  = $urandom_range(2, 8);
        dbase = $urandom_range(0, MEM_WORDS - 8);
        for (int i = 0; i < plen; i++) begin
            a = dbase + $urandom_range(0, 7);
            b = dbase + $urandom_range(0, 7);
            c = pbase + $urandom_range(0, plen - 1);
            if ($urandom_range(0, 11) == 0) a = $urandom_range(MEM_WORDS, OPERAND_MAX);
            if ($urandom_range(0, 11) == 0) b = $urandom_range(MEM_WORDS, OPERAND_MAX);
            if ($urandom_range(0, 7) == 0)  c = $urandom_range(0, OPERAND_MAX);
            send_item(subleq_pkg::CMD_WRITE, 8'(pbase + i), pack_instruction(a, b, c));
        end
        for (int j = 0; j < 8; j++)
            if ($urandom_range(0, 1) == 0)
                send_item(subleq_pkg::CMD_WRITE, 8'(dbase + j), pick_data());
        send_item(subleq_pkg::CMD_SETPC, 8'(pbase), rand_word());
        repeat ($urandom_range(4, 20)) begin
            if ($urandom_range(0, 5) == 0)
                send_item(subleq_pkg::CMD_READ, 8'($urandom_range(0, 255)), rand_word());
            else
                send_item(subleq_pkg::CMD_EXEC, 8'($urandom_range(0, 255)), rand_word());
        end
    endtask

    initial begin
        int unsigned settle;
        sb         = new();
        allow_gaps = 1'b0;
        items_sent = 0;
        i_rst_n    = 1'b0;
        start      = 1'b0;
        i_cmd      = subleq_pkg::CMD_WRITE;
        i_addr     = '0;
        i_wdata    = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: address limits, every command, each corner of execute.
        send_item(subleq_pkg::CMD_READ,  8'd0,   '0);
        send_item(subleq_pkg::CMD_WRITE, 8'd127, '1);
        send_item(subleq_pkg::CMD_WRITE, 8'd128, rand_word());
        send_item(subleq_pkg::CMD_WRITE, 8'd255, rand_word());
        send_item(subleq_pkg::CMD_READ,  8'd127, '0);
        send_item(subleq_pkg::CMD_READ,  8'd200, '0);
        send_item(subleq_pkg::CMD_WRITE, 8'd0, pack_instruction(1, 2, 5));
        send_item(subleq_pkg::CMD_WRITE, 8'd1, 64'd5);
        send_item(subleq_pkg::CMD_WRITE, 8'd2, 64'd3);
        send_item(subleq_pkg::CMD_EXEC,  8'd0, '0);      // negative difference, branch taken
        send_item(subleq_pkg::CMD_EXEC,  8'd0, '0);      // empty word: zero difference, branch to 0
        send_item(subleq_pkg::CMD_WRITE, 8'd2, 64'd10);
        send_item(subleq_pkg::CMD_EXEC,  8'd0, '0);      // positive difference, falls through
        send_item(subleq_pkg::CMD_SETPC, 8'd255, '0);
        send_item(subleq_pkg::CMD_EXEC,  8'd0, '0);      // halted
        send_item(subleq_pkg::CMD_SETPC, 8'd128, '0);
        send_item(subleq_pkg::CMD_EXEC,  8'd0, '0);
        send_item(subleq_pkg::CMD_WRITE, 8'd10, pack_instruction(200, 1, 0));
        send_item(subleq_pkg::CMD_SETPC, 8'd10, '0);
        send_item(subleq_pkg::CMD_EXEC,  8'd0, '0);      // operand A outside memory
        send_item(subleq_pkg::CMD_WRITE, 8'd10, pack_instruction(1, OPERAND_MAX, 0));
        send_item(subleq_pkg::CMD_EXEC,  8'd0, '0);      // operand B outside memory
        send_item(subleq_pkg::CMD_WRITE, 8'd11, pack_instruction(3, 3, OPERAND_MAX));
        send_item(subleq_pkg::CMD_SETPC, 8'd11, '0);
        send_item(subleq_pkg::CMD_EXEC,  8'd0, '0);      // jump target beyond memory halts
        send_item(subleq_pkg::CMD_WRITE, 8'd127, pack_instruction(1, 6, 0));
        send_item(subleq_pkg::CMD_WRITE, 8'd6, 64'd100);
        send_item(subleq_pkg::CMD_SETPC, 8'd127, '0);
        send_item(subleq_pkg::CMD_EXEC,  8'd0, '0);      // falls off the end of memory
        drain_results();

        items_sent = 0;
        while (items_sent < RANDOM_ITEMS) begin
            if (items_sent >= RANDOM_ITEMS - QUIET_TAIL) allow_gaps = 1'b0;
            else allow_gaps = ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5, 6: run_program();
                7: begin
                    repeat ($urandom_range(1, 8))
                        send_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                                  rand_word());
                end
                8: begin
                    repeat ($urandom_range(1, 6))
                        send_item(subleq_pkg::CMD_READ, 8'($urandom_range(0, 255)),
                                  rand_word());
                end
                default: drain_results();
            endcase
        end

        start  <= 1'b0;
        settle = 0;
        while (sb.pending() > 0 && settle < 1000) begin
            @(posedge i_clk);
            settle++;
        end
        repeat (8) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("subleq_processor_core_unit test passed");
        end else begin
            $display("subleq_processor_core_unit test failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ----- subleq_processor_core_unit.f -----
+incdir+rtl
rtl/subleq_pkg.sv
rtl/subleq_mem.sv
rtl/subleq_seq.sv
rtl/subleq_dp.sv
rtl/subleq_processor_core_unit.sv
rtl/subleq_chk.sv
verif/tb_top.sv
